// ===== rtl/spud_pkg.sv =====
// Shared types, constants and the frame header table for the SysEx parameter
// update deframer. No dependencies.
package spud_pkg;

    localparam int MAX_UPDATES_DEF = 16;
    localparam int Q_DEPTH         = 4;
    localparam int Q_AW            = $clog2(Q_DEPTH);

    localparam logic [3:0] WATCH_RESET = 4'd3;
    localparam logic [7:0] FRAME_CAP   = 8'd255;
    localparam logic [7:0] HDR_LEN     = 8'd6;

    localparam logic [7:0] SYX_START = 8'hF0;
    localparam logic [7:0] SYX_END   = 8'hF7;
    localparam logic [7:0] RT_MIN    = 8'hF8;

    localparam logic FUNC_BYTE  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic        clr;
        logic [4:0]  idx;
        logic [11:0] val;
        logic        last;
    } t_cmd;

    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd0:    b = 8'hF0;
            3'd1:    b = 8'h00;
            3'd2:    b = 8'h20;
            3'd3:    b = 8'h0D;
            3'd4:    b = 8'h71;
            3'd5:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/spud_front.sv =====
// Front end: accepts MIDI bytes and clear commands, parses frames, holds
// watched updates in a small memory and drains them into the queue. Uses spud_pkg.
module spud_front #(
    parameter int MAX_UPDATES = spud_pkg::MAX_UPDATES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic [7:0]        i_data_byte,
    input  logic              i_cfg_wr_en,
    input  logic [3:0]        i_cfg_wr_data,
    output logic              o_push,
    output spud_pkg::t_cmd    o_push_data,
    input  logic              i_q_full
);
    import spud_pkg::*;

    localparam int CW = $clog2(MAX_UPDATES + 1);
    localparam int AW = (MAX_UPDATES > 1) ? $clog2(MAX_UPDATES) : 1;

    localparam logic [1:0] ST_PARSE = 2'd0;
    localparam logic [1:0] ST_RD    = 2'd1;
    localparam logic [1:0] ST_PUSH  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [7:0]    r_len, n_len;
    logic          r_hg, n_hg;
    logic          r_ovf, n_ovf;
    logic          r_stop, n_stop;
    logic [13:0]   r_trip, n_trip;
    logic [1:0]    r_pos, n_pos;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_drain_cnt, n_drain_cnt;
    logic [3:0]    r_watch;
    logic [16:0]   r_rd_data;
    logic [16:0]   r_mem [MAX_UPDATES];

    logic          acc, is_clear, is_start, is_end;
    logic [7:0]    b_len;
    logic          b_hg, b_ovf, b_stop;
    logic [13:0]   b_trip;
    logic [1:0]    b_pos;
    logic [CW-1:0] b_cnt;
    logic          wr_en, rd_en, frame_ok, drain_last;
    logic [AW-1:0] wr_addr;
    logic [16:0]   wr_data;
    logic [6:0]    trip_b0, trip_b1;

    assign o_stall  = (r_state != ST_PARSE) || i_q_full;
    assign acc      = i_valid && !o_stall;
    assign is_clear = (i_func == FUNC_CLEAR);
    assign is_start = (i_data_byte == SYX_START);
    assign is_end   = (i_data_byte == SYX_END);
    assign trip_b0  = r_trip[13:7];
    assign trip_b1  = r_trip[6:0];

    assign b_len  = is_start ? 8'd0 : r_len;
    assign b_hg   = is_start ? 1'b0 : r_hg;
    assign b_ovf  = is_start ? 1'b0 : r_ovf;
    assign b_stop = is_start ? 1'b0 : r_stop;
    assign b_trip = is_start ? 14'd0 : r_trip;
    assign b_pos  = is_start ? 2'd0 : r_pos;
    assign b_cnt  = is_start ? '0 : r_cnt;

    assign drain_last = ((r_rd_idx + CW'(1)) == r_drain_cnt);
    assign rd_en      = (r_state == ST_RD);

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_hg        = r_hg;
        n_ovf       = r_ovf;
        n_stop      = r_stop;
        n_trip      = r_trip;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_rd_idx    = r_rd_idx;
        n_drain_cnt = r_drain_cnt;
        wr_en       = 1'b0;
        wr_addr     = b_cnt[AW-1:0];
        wr_data     = {trip_b0[2:0], trip_b1[6:5], trip_b1[4:0], i_data_byte[6:0]};
        frame_ok    = 1'b0;
        o_push      = 1'b0;
        o_push_data = '{clr: 1'b0, idx: r_rd_data[16:12], val: r_rd_data[11:0],
                        last: drain_last};

        unique case (r_state)
            ST_PARSE: begin
                if (acc && is_clear) begin
                    o_push      = 1'b1;
                    o_push_data = '{clr: 1'b1, idx: 5'd0, val: 12'd0, last: 1'b0};
                end else if (acc && i_data_byte < RT_MIN) begin
                    n_len  = b_len;
                    n_hg   = b_hg;
                    n_ovf  = b_ovf;
                    n_stop = b_stop;
                    n_trip = b_trip;
                    n_pos  = b_pos;
                    n_cnt  = b_cnt;
                    if (!b_ovf) begin
                        if (b_len != FRAME_CAP) begin
                            if (b_len == 8'd0) begin
                                n_hg = is_start;
                            end else if (b_len < HDR_LEN) begin
                                n_hg = b_hg && (i_data_byte == hdr_byte(b_len[2:0]));
                            end else if (!is_end) begin
                                n_pos = (b_pos == 2'd2) ? 2'd0 : b_pos + 2'd1;
                                if (!b_stop) begin
                                    if (i_data_byte[7]) begin
                                        n_stop = 1'b1;
                                    end else if (b_pos != 2'd2) begin
                                        n_trip = {b_trip[6:0], i_data_byte[6:0]};
                                    end else if (trip_b0[6:3] == r_watch &&
                                                 b_cnt < CW'(MAX_UPDATES)) begin
                                        wr_en = 1'b1;
                                        n_cnt = b_cnt + CW'(1);
                                    end
                                end
                            end
                            n_len = b_len + 8'd1;
                        end else begin
                            n_ovf = 1'b1;
                            n_len = 8'd0;
                        end
                    end
                    if (is_end) begin
                        frame_ok = !n_ovf && n_hg && (b_len >= HDR_LEN) && (b_pos == 2'd0);
                        if (frame_ok && b_cnt != '0) begin
                            n_state     = ST_RD;
                            n_rd_idx    = '0;
                            n_drain_cnt = b_cnt;
                        end
                        n_len  = 8'd0;
                        n_hg   = 1'b0;
                        n_ovf  = 1'b0;
                        n_stop = 1'b0;
                        n_trip = 14'd0;
                        n_pos  = 2'd0;
                        n_cnt  = '0;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                o_push = 1'b1;
                if (!i_q_full) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_state  = drain_last ? ST_PARSE : ST_RD;
                end
            end
            default: begin
                n_state = ST_PARSE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_PARSE;
            r_len       <= 8'd0;
            r_hg        <= 1'b0;
            r_ovf       <= 1'b0;
            r_stop      <= 1'b0;
            r_trip      <= 14'd0;
            r_pos       <= 2'd0;
            r_cnt       <= '0;
            r_rd_idx    <= '0;
            r_drain_cnt <= '0;
            r_watch     <= WATCH_RESET;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_hg        <= n_hg;
            r_ovf       <= n_ovf;
            r_stop      <= n_stop;
            r_trip      <= n_trip;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_rd_idx    <= n_rd_idx;
            r_drain_cnt <= n_drain_cnt;
            if (i_cfg_wr_en) begin
                r_watch <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
        end
    end

endmodule

// ===== rtl/spud_fifo.sv =====
// Short command queue between the front end and the update back end.
// Uses spud_pkg for the command type and depth.
module spud_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  spud_pkg::t_cmd    i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output spud_pkg::t_cmd    o_pop_data,
    output logic              o_empty
);
    import spud_pkg::*;

    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]   r_count;
    t_cmd            r_mem [Q_DEPTH];

    assign o_full     = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (Q_AW + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (Q_AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/spud_back.sv =====
// Back end: pops queued commands, keeps the seen mask and drives the
// registered result channel. Uses spud_pkg.
module spud_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spud_pkg::t_cmd    i_cmd,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [4:0]        o_param_index,
    output logic signed [11:0] o_param_value,
    output logic [31:0]       o_seen_mask,
    output logic              o_last
);
    import spud_pkg::*;

    logic        r_ovalid;
    logic [31:0] r_mask, n_mask;
    logic [4:0]  r_idx;
    logic [11:0] r_val;
    logic [31:0] r_omask;
    logic        r_last;

    assign o_pop  = !i_empty && (!r_ovalid || !i_stall);
    assign n_mask = r_mask | (32'd1 << i_cmd.idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_mask   <= 32'd0;
        end else begin
            if (o_pop && !i_cmd.clr) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop) begin
                r_mask <= i_cmd.clr ? 32'd0 : n_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_cmd.clr) begin
            r_idx   <= i_cmd.idx;
            r_val   <= i_cmd.val;
            r_omask <= n_mask;
            r_last  <= i_cmd.last;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_param_index = r_idx;
    assign o_param_value = $signed(r_val);
    assign o_seen_mask   = r_omask;
    assign o_last        = r_last;

endmodule

// ===== rtl/sysex_parameter_update_deframer.sv =====
// SysEx parameter update deframer, top level: front end, command queue, back end.
// Depends on spud_pkg, spud_front, spud_fifo, spud_back.
// Each byte or clear command is taken in one cycle while no frame is draining
// and the queue has room. A frame-ending F7 that releases updates stalls the
// input while they drain (one pending-memory read and one queue push per
// update, the push waiting while the queue is full).
// Synchronous active-low reset clears frame state, queue, seen mask and output
// valid, and sets the watched address to 3; the pending memory is not cleared.
module sysex_parameter_update_deframer #(
    parameter int MAX_UPDATES = spud_pkg::MAX_UPDATES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic [7:0]        i_data_byte,
    input  logic              i_cfg_wr_en,
    input  logic [3:0]        i_cfg_wr_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [4:0]        o_param_index,
    output logic signed [11:0] o_param_value,
    output logic [31:0]       o_seen_mask,
    output logic              o_last
);
    import spud_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    t_cmd q_in, q_out;

    spud_front #(.MAX_UPDATES(MAX_UPDATES)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_data_byte   (i_data_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (q_push),
        .o_push_data   (q_in),
        .i_q_full      (q_full)
    );

    spud_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push && !q_full),
        .i_push_data (q_in),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_out),
        .o_empty     (q_empty)
    );

    spud_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (q_out),
        .i_empty       (q_empty),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_param_index (o_param_index),
        .o_param_value (o_param_value),
        .o_seen_mask   (o_seen_mask),
        .o_last        (o_last)
    );

    a_clear_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> !q_full)
        else $error("input transfer taken while queue full");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_mask_has_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_seen_mask[o_param_index])
        else $error("result seen mask lacks its own index");

endmodule

// ===== tb/deframer_checker.sv =====
// Scoreboard for sysex_parameter_update_deframer: follows byte, clear and config
// transfers, predicts the released parameter updates and compares the output.
// Depends on spud_pkg.
module deframer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [4:0]  i_param_index,
    input  logic [11:0] i_param_value,
    input  logic [31:0] i_seen_mask,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_expect_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import spud_pkg::*;

    localparam int MAX_UPD = MAX_UPDATES_DEF;
    localparam logic [7:0] SYX_HDR [0:5] = '{8'hF0, 8'h00, 8'h20, 8'h0D, 8'h71, 8'h01};

    typedef struct packed {
        logic [4:0]  idx;
        logic [11:0] val;
        logic [31:0] mask;
        logic        final_upd;
    } t_update;

    t_update     owed_updates[$];
    int          fails = 0;
    int          owed_count = 0;

    logic [3:0]  watch_addr;
    int          frame_len;
    bit          hdr_ok;
    bit          overflowed;
    bit          decode_halted;
    logic [13:0] trip_acc;
    logic [4:0]  held_idx [MAX_UPD];
    logic [11:0] held_val [MAX_UPD];
    int          held_n;
    logic [31:0] seen;

    assign o_fail_count   = fails;
    assign o_expect_count = owed_count;

    task automatic clear_frame();
        frame_len     = 0;
        hdr_ok        = 1'b0;
        overflowed    = 1'b0;
        decode_halted = 1'b0;
        trip_acc      = '0;
        held_n        = 0;
    endtask

    task automatic decode_payload(input logic [7:0] b);
        int         pos;
        logic [6:0] b0;
        logic [6:0] b1;
        pos = (frame_len - int'(HDR_LEN)) % 3;
        if (decode_halted)
            return;
        if (b[7]) begin
            decode_halted = 1'b1;
            return;
        end
        if (pos < 2) begin
            trip_acc = {trip_acc[6:0], b[6:0]};
            return;
        end
        b0 = trip_acc[13:7];
        b1 = trip_acc[6:0];
        if (b0[6:3] == watch_addr && held_n < MAX_UPD) begin
            held_idx[held_n] = {b0[2:0], b1[6:5]};
            held_val[held_n] = {b1[4:0], b[6:0]};
            held_n++;
        end
    endtask

    task automatic advance_deframer(input logic f, input logic [7:0] b);
        if (f == FUNC_CLEAR) begin
            seen = '0;
            return;
        end
        if (b >= RT_MIN)
            return;
        if (b == SYX_START)
            clear_frame();
        if (!overflowed) begin
            if (frame_len < int'(FRAME_CAP)) begin
                if (frame_len == 0)
                    hdr_ok = (b == SYX_START);
                else if (frame_len < int'(HDR_LEN))
                    hdr_ok = hdr_ok && (b == SYX_HDR[frame_len]);
                else if (b != SYX_END)
                    decode_payload(b);
                frame_len++;
            end else begin
                overflowed = 1'b1;
                frame_len  = 0;
            end
        end
        if (b == SYX_END) begin
            if (!overflowed && hdr_ok && frame_len >= int'(HDR_LEN) + 1 &&
                (frame_len - int'(HDR_LEN) - 1) % 3 == 0) begin
                for (int k = 0; k < held_n; k++) begin
                    seen[held_idx[k]] = 1'b1;
                    owed_updates.push_back('{held_idx[k], held_val[k], seen, k == held_n - 1});
                end
            end
            clear_frame();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_update want;
        if (!i_rst_n) begin
            watch_addr = WATCH_RESET;
            seen       = '0;
            clear_frame();
            owed_updates.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_updates.size() == 0) begin
                    $display("%0t ns: unexpected update, index %0d value 0x%0h",
                             $time, i_param_index, i_param_value);
                    fails++;
                end else begin
                    want = owed_updates.pop_front();
                    check_field("param_index", want.idx, i_param_index);
                    check_field("param_value", want.val, i_param_value);
                    check_field("seen_mask", want.mask, i_seen_mask);
                    check_field("last", want.final_upd, i_last);
                end
            end
            if (i_cfg_wr_en)
                watch_addr = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall)
                advance_deframer(i_func, i_data_byte);
        end
        owed_count <= owed_updates.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the deframer testbench: clock, reset, byte stimulus with random bursts,
// receiver stalls, config changes and the verdict.
// Depends on spud_pkg, sysex_parameter_update_deframer and deframer_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import spud_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_ITEMS = 24;
    localparam int CFG_EVERY    = 12;
    localparam int SETTLE       = 20;

    typedef enum int {
        FLAW_NONE,
        FLAW_HEADER,
        FLAW_PARTIAL,
        FLAW_HIGHBIT,
        FLAW_RESTART,
        FLAW_SHORT,
        FLAW_UNCLOSED
    } t_frame_flaw;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               func;
    logic [7:0]         data_byte;
    logic               cfg_wr_en;
    logic [3:0]         cfg_wr_data;
    logic               out_valid;
    logic               out_stall;
    logic [4:0]         param_index;
    logic signed [11:0] param_value;
    logic [31:0]        seen_mask;
    logic               upd_last;
    int                 fail_count;
    int                 expect_count;

    int         idle_cycles   = 0;
    int         items_sent    = 0;
    int         burst_left    = 0;
    int         holds_wanted  = 0;
    int         holds_started = 0;
    bit         inject        = 1'b0;
    logic [3:0] watch_now     = WATCH_RESET;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sysex_parameter_update_deframer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_func        (func),
        .i_data_byte   (data_byte),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_param_index (param_index),
        .o_param_value (param_value),
        .o_seen_mask   (seen_mask),
        .o_last        (upd_last)
    );

    deframer_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_func         (func),
        .i_data_byte    (data_byte),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_param_index  (param_index),
        .i_param_value  (param_value),
        .i_seen_mask    (seen_mask),
        .i_last         (upd_last),
        .o_fail_count   (fail_count),
        .o_expect_count (expect_count)
    );

    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : receiver
        int seg;
        int mode;
        out_stall <= 1'b0;
        @(posedge clk);
        forever begin
            if (holds_started < holds_wanted) begin
                holds_started++;
                repeat (HOLD_CYCLES) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            seg  = $urandom_range(4, 40);
            mode = $urandom_range(0, 3);
            repeat (seg) begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // one transfer; valid stays up inside a burst, drops for a gap after it
    task automatic send(input logic f, input logic [7:0] b);
        in_valid  <= 1'b1;
        func      <= f;
        data_byte <= b;
        do @(posedge clk); while (in_stall);
        if (f == FUNC_CLEAR || b < RT_MIN)
            items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 3))
                @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic put_byte(input logic [7:0] b);
        if (inject && $urandom_range(0, 19) == 0)
            send(FUNC_BYTE, 8'(RT_MIN + $urandom_range(0, 7)));
        if (inject && $urandom_range(0, 39) == 0)
            send(FUNC_CLEAR, 8'($urandom));
        send(FUNC_BYTE, b);
    endtask

    function automatic logic [11:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 12'h800;
            1:       return 12'h7FF;
            2:       return 12'h000;
            3:       return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    // high_at >= 0 puts a status byte into that slot of the triplet
    task automatic put_triplet(input logic [3:0] a, input logic [4:0] idx,
                               input logic [11:0] val, input int high_at);
        logic [7:0] trip_b [3];
        int         hb;
        trip_b[0] = {1'b0, a, idx[4:2]};
        trip_b[1] = {1'b0, idx[1:0], val[11:7]};
        trip_b[2] = {1'b0, val[6:0]};
        if (high_at >= 0) begin
            hb = $urandom_range(128, 245);
            if (hb >= 240)
                hb++;
            trip_b[high_at] = 8'(hb);
        end
        foreach (trip_b[j])
            put_byte(trip_b[j]);
    endtask

    // cut_at > 0 ends the frame with F7 at that header position
    task automatic put_header(input int bad_at, input int cut_at);
        logic [7:0] b;
        put_byte(SYX_START);
        for (int p = 1; p < 6; p++) begin
            if (p == cut_at) begin
                put_byte(SYX_END);
                return;
            end
            b = hdr_byte(3'(p));
            if (p == bad_at)
                b = b ^ (8'h01 << $urandom_range(0, 6));
            put_byte(b);
        end
    endtask

    task automatic send_frame(input int n_trip, input int watch_pct, input t_frame_flaw flaw);
        int         bad_pos;
        int         bad_trip;
        logic [3:0] a;
        bad_pos  = $urandom_range(1, 5);
        bad_trip = (n_trip > 0) ? $urandom_range(0, n_trip - 1) : 0;
        if (flaw == FLAW_RESTART) begin
            put_byte(SYX_START);
            repeat ($urandom_range(0, 8))
                put_byte(8'($urandom_range(0, 127)));
        end
        put_header(flaw == FLAW_HEADER ? bad_pos : 0, flaw == FLAW_SHORT ? bad_pos : 0);
        if (flaw == FLAW_SHORT)
            return;
        for (int t = 0; t < n_trip; t++) begin
            a = ($urandom_range(0, 99) < watch_pct) ? watch_now : 4'($urandom_range(0, 15));
            put_triplet(a, 5'($urandom), pick_value(),
                        (flaw == FLAW_HIGHBIT && t == bad_trip) ? $urandom_range(0, 2) : -1);
        end
        if (flaw == FLAW_PARTIAL)
            repeat ($urandom_range(1, 2))
                put_byte(8'($urandom_range(0, 127)));
        if (flaw != FLAW_UNCLOSED)
            put_byte(SYX_END);
    endtask

    task automatic drain_updates();
        in_valid <= 1'b0;
        do @(posedge clk); while (expect_count != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_watch(input logic [3:0] a);
        drain_updates();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        watch_now = a;
    endtask

    initial begin : stimulus
        int rand_start;
        int next_cfg;
        int cfg_step;
        int kind;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= FUNC_BYTE;
        data_byte   <= 8'h00;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 4'h0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, real-time bytes, clear, stray and empty frames
        put_header(0, 0);
        put_triplet(WATCH_RESET, 5'd0, 12'h7FF, -1);
        put_byte(RT_MIN);
        put_triplet(WATCH_RESET, 5'd31, 12'h800, -1);
        put_triplet(4'd5, 5'd4, 12'h000, -1);
        put_byte(8'hFF);
        put_byte(SYX_END);
        send(FUNC_CLEAR, 8'hFF);
        put_byte(8'h7F);
        put_byte(SYX_END);
        put_byte(SYX_START);
        put_byte(SYX_END);
        drain_updates();

        // back-pressure: output held off while two update-heavy frames arrive,
        // the second with more watched updates than a frame can hold
        inject = 1'b1;
        holds_wanted++;
        while (holds_started < holds_wanted)
            @(posedge clk);
        send_frame(6, 100, FLAW_NONE);
        send_frame(MAX_UPDATES_DEF + 1, 100, FLAW_NONE);

        set_watch(4'h0);

        rand_start = items_sent;
        next_cfg   = items_sent + CFG_EVERY;
        cfg_step   = 0;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            if (items_sent >= next_cfg) begin
                put_byte(SYX_END);
                set_watch(cfg_step == 0 ? 4'hF : 4'($urandom_range(0, 15)));
                cfg_step++;
                next_cfg = items_sent + CFG_EVERY;
            end
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                send_frame($urandom_range(0, 5), 70, FLAW_NONE);
            end else if (kind < 17) begin
                send_frame($urandom_range(1, 4), 70, t_frame_flaw'($urandom_range(1, 6)));
            end else if (kind < 19) begin
                repeat ($urandom_range(1, 6))
                    put_byte(8'($urandom));
                put_byte(SYX_END);
            end else begin
                send_frame($urandom_range(6, 8), 90, FLAW_NONE);
            end
        end

        drain_updates();
        if (fail_count == 0 && expect_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
